// ----- rtl/core/stftola_pkg.sv -----
// Shared constants, types and command codes of the overlap-add reconstruction block.
package stftola_pkg;

   localparam int MAX_FRAME_LEN = 1024;
   localparam int MAX_FRAMES    = 16;
   localparam int SAMPLE_BITS   = 24;

   // fixed field widths
   localparam int OP_BITS         = 2;
   localparam int FIDX_BITS       = 4;
   localparam int SIDX_BITS       = 10;
   localparam int VALUE_BITS      = 24;
   localparam int OUT_SAMPLE_BITS = 24;
   localparam int WIN_BITS        = 18;
   localparam int CFG_LEN_BITS    = 11;
   localparam int CFG_HOP_BITS    = 11;
   localparam int CFG_CNT_BITS    = 5;

   // derived widths
   localparam int POS_BITS   = $clog2(MAX_FRAME_LEN);
   localparam int LEN_BITS   = $clog2(MAX_FRAME_LEN) + 1;
   localparam int SLOT_BITS  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_BITS   = $clog2(MAX_FRAMES) + 1;
   localparam int OFF_BITS   = SLOT_BITS + CFG_HOP_BITS;
   localparam int FADDR_BITS = SLOT_BITS + POS_BITS;
   localparam int ACC_BITS   = SAMPLE_BITS + SLOT_BITS + 1;
   localparam int PROD_BITS  = SAMPLE_BITS + WIN_BITS;
   localparam int ROUND_SHIFT = 16;
   localparam int RND_BITS   = PROD_BITS - ROUND_SHIFT;

   localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH) + 1;

   // register port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_ADDR_BITS = CSR_IDX_BITS + 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_LENGTH = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_HOP_SIZE     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_COUNT  = 2'd2;

   localparam logic [CFG_LEN_BITS-1:0] FRAME_LENGTH_RESET = 11'd1024;
   localparam logic [CFG_HOP_BITS-1:0] HOP_SIZE_RESET     = 11'd256;
   localparam logic [CFG_CNT_BITS-1:0] FRAME_COUNT_RESET  = 5'd16;

   // operation codes on the request channel
   localparam logic [OP_BITS-1:0] OP_LOAD_FRAME = 2'd0;
   localparam logic [OP_BITS-1:0] OP_LOAD_WIN   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_COMPUTE    = 2'd2;

   typedef enum logic [1:0] {
      CMD_LOAD_FRAME,
      CMD_LOAD_WIN,
      CMD_COMPUTE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                 kind;
      logic [FIDX_BITS-1:0]         frame_index;
      logic [SIDX_BITS-1:0]         sample_index;
      logic signed [VALUE_BITS-1:0] value;
      logic [POS_BITS-1:0]          k;
   } cmd_type;

   typedef struct packed {
      logic [LEN_BITS-1:0]     len;
      logic [LEN_BITS-1:0]     lo;
      logic [LEN_BITS-1:0]     hi;
      logic [CFG_HOP_BITS-1:0] hop;
      logic [CNT_BITS-1:0]     cnt;
   } cfg_type;

   typedef struct packed {
      logic pop;
      logic busy;
   } stat_type;

endpackage

// ----- rtl/core/stft_frame_overlap_add_window.sv -----
// Overlap-add frame reconstruction: software loads frame samples (Q1.23) and window
// values (Q2.16) through the request channel, then each compute request returns one
// windowed, overlap-added sample (Q1.23, saturating). Requests pass through a two-entry
// command queue, so the request side keeps moving while a result waits, until the queue
// fills. A frame or window load is written in the back end when taken from the queue. A
// compute holds the back end, and waits on rsp_stall to hand over its result: one term
// for each of the 16 frame slots, issued one per cycle through a three-stage address
// pipeline with a frame store read for each slot that contributes, followed by
// saturation, the window multiply and rounding. Results come out in request
// order; loads and invalid computes give none.
module stft_frame_overlap_add_window import stftola_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [OP_BITS-1:0]                req_operation,
   input  logic [FIDX_BITS-1:0]              req_frame_index,
   input  logic [SIDX_BITS-1:0]              req_sample_index,
   input  logic signed [VALUE_BITS-1:0]      req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [SIDX_BITS-1:0]              rsp_out_index,
   output logic signed [OUT_SAMPLE_BITS-1:0] rsp_out_sample,
   output logic                              rsp_saturated,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [CSR_ADDR_BITS-1:0]          paddr,
   input  logic [CSR_DATA_BITS-1:0]          pwdata,
   output logic [CSR_DATA_BITS-1:0]          prdata,
   output logic                              pready
);

   logic [CFG_LEN_BITS-1:0] frame_length_ff, frame_length_in;
   logic [CFG_HOP_BITS-1:0] hop_size_ff, hop_size_in;
   logic [CFG_CNT_BITS-1:0] frame_count_ff, frame_count_in;
   logic                    csr_write;
   logic [CSR_IDX_BITS-1:0] csr_idx;

   cfg_type  cfg;
   cmd_type  head;
   logic     head_valid;
   logic     pop;
   stat_type stat;

   assign pready    = 1'b1;
   assign csr_idx   = paddr[CSR_ADDR_BITS-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      frame_length_in = frame_length_ff;
      hop_size_in     = hop_size_ff;
      frame_count_in  = frame_count_ff;
      if (csr_write) begin
         case (csr_idx)
            REG_FRAME_LENGTH: frame_length_in = pwdata[CFG_LEN_BITS-1:0];
            REG_HOP_SIZE:     hop_size_in     = pwdata[CFG_HOP_BITS-1:0];
            REG_FRAME_COUNT:  frame_count_in  = pwdata[CFG_CNT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_FRAME_LENGTH: prdata = CSR_DATA_BITS'(frame_length_ff);
         REG_HOP_SIZE:     prdata = CSR_DATA_BITS'(hop_size_ff);
         REG_FRAME_COUNT:  prdata = CSR_DATA_BITS'(frame_count_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= FRAME_LENGTH_RESET;
         hop_size_ff     <= HOP_SIZE_RESET;
         frame_count_ff  <= FRAME_COUNT_RESET;
      end else begin
         frame_length_ff <= frame_length_in;
         hop_size_ff     <= hop_size_in;
         frame_count_ff  <= frame_count_in;
      end
   end

   stftola_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_frame_index (req_frame_index),
      .req_sample_index(req_sample_index),
      .req_value       (req_value),
      .frame_length    (frame_length_ff),
      .hop_size        (hop_size_ff),
      .frame_count     (frame_count_ff),
      .cfg             (cfg),
      .head            (head),
      .head_valid      (head_valid),
      .pop             (pop)
   );

   stftola_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .head          (head),
      .head_valid    (head_valid),
      .pop           (pop),
      .stat          (stat),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_out_index (rsp_out_index),
      .rsp_out_sample(rsp_out_sample),
      .rsp_saturated (rsp_saturated)
   );

   // the back end takes a command only when the queue holds one
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      stat.pop |-> head_valid)
      else $error("command taken from an empty queue");

   // a result appears only at the end of a compute sequence
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(stat.busy))
      else $error("result raised without a compute in progress");

   // no new command while a compute sequence runs
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      stat.busy |-> !stat.pop)
      else $error("command taken while the back end is busy");

endmodule

// ----- rtl/core/stftola_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module stftola_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/stftola_front.sv -----
// Request front end: config clamping, item classification and the command queue.
module stftola_front import stftola_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [OP_BITS-1:0]           req_operation,
   input  logic [FIDX_BITS-1:0]         req_frame_index,
   input  logic [SIDX_BITS-1:0]         req_sample_index,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic [CFG_LEN_BITS-1:0]      frame_length,
   input  logic [CFG_HOP_BITS-1:0]      hop_size,
   input  logic [CFG_CNT_BITS-1:0]      frame_count,
   output cfg_type                      cfg,
   output cmd_type                      head,
   output logic                         head_valid,
   input  logic                         pop
);

   cmd_type              q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   cfg_type         cfg_c;
   cmd_type         cmd;
   logic            keep;
   logic            accept;
   logic            push;
   logic [LEN_BITS:0] k_sum;

   // clamp the registers to the ranges the datapath handles
   always_comb begin
      if (frame_length == '0) begin
         cfg_c.len = LEN_BITS'(1);
      end else if (frame_length > MAX_FRAME_LEN) begin
         cfg_c.len = LEN_BITS'(MAX_FRAME_LEN);
      end else begin
         cfg_c.len = LEN_BITS'(frame_length);
      end
      cfg_c.lo  = cfg_c.len >> 1;
      cfg_c.hi  = cfg_c.len - cfg_c.lo;
      cfg_c.hop = hop_size;
      if (frame_count > MAX_FRAMES) begin
         cfg_c.cnt = CNT_BITS'(MAX_FRAMES);
      end else begin
         cfg_c.cnt = CNT_BITS'(frame_count);
      end
   end

   assign cfg = cfg_c;

   // compute position inside the rotated frame
   assign k_sum = (LEN_BITS+1)'(req_sample_index) + (LEN_BITS+1)'(cfg_c.hi);

   always_comb begin
      cmd.frame_index  = req_frame_index;
      cmd.sample_index = req_sample_index;
      cmd.value        = req_value;
      if (k_sum >= (LEN_BITS+1)'(cfg_c.len)) begin
         cmd.k = POS_BITS'(k_sum - (LEN_BITS+1)'(cfg_c.len));
      end else begin
         cmd.k = POS_BITS'(k_sum);
      end
      cmd.kind = CMD_COMPUTE;
      keep     = 1'b0;
      case (req_operation)
         OP_LOAD_FRAME: begin
            cmd.kind = CMD_LOAD_FRAME;
            keep     = (req_frame_index < MAX_FRAMES) && (req_sample_index < MAX_FRAME_LEN);
         end
         OP_LOAD_WIN: begin
            cmd.kind = CMD_LOAD_WIN;
            keep     = (req_sample_index < MAX_FRAME_LEN);
         end
         OP_COMPUTE: begin
            cmd.kind = CMD_COMPUTE;
            keep     = (req_frame_index < MAX_FRAMES) && (req_sample_index < cfg_c.len);
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   // drop items that leave no trace
   assign push      = accept && keep;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head       = q_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);

endmodule

// ----- rtl/core/stftola_back.sv -----
// Command back end: store writes, per-frame overlap-add sequencer, window multiply.
module stftola_back import stftola_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  cfg_type                           cfg,
   input  cmd_type                           head,
   input  logic                              head_valid,
   output logic                              pop,
   output stat_type                          stat,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [SIDX_BITS-1:0]              rsp_out_index,
   output logic signed [OUT_SAMPLE_BITS-1:0] rsp_out_sample,
   output logic                              rsp_saturated
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_TERMS = 5'b00010,
      ST_CLIP  = 5'b00100,
      ST_MUL   = 5'b01000,
      ST_ROUND = 5'b10000
   } state_type;

   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(MAX_FRAMES - 1);
   localparam logic signed [ACC_BITS-1:0]  ACC_MAX = ACC_BITS'(SAMPLE_MAX);
   localparam logic signed [ACC_BITS-1:0]  ACC_MIN = ACC_BITS'(SAMPLE_MIN);
   localparam logic signed [RND_BITS-1:0]  RND_MAX = RND_BITS'(SAMPLE_MAX);
   localparam logic signed [RND_BITS-1:0]  RND_MIN = RND_BITS'(SAMPLE_MIN);
   localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
      PROD_BITS'(longint'(1) << (ROUND_SHIFT - 1));
   localparam logic signed [SAMPLE_BITS-1:0] SUM_MAX = SAMPLE_BITS'(SAMPLE_MAX);
   localparam logic signed [SAMPLE_BITS-1:0] SUM_MIN = SAMPLE_BITS'(SAMPLE_MIN);

   state_type state_ff, state_in;

   // current compute command
   logic [FIDX_BITS-1:0] cur_fi_ff, cur_fi_in;
   logic [SIDX_BITS-1:0] cur_si_ff, cur_si_in;
   logic [POS_BITS-1:0]  cur_k_ff, cur_k_in;

   // term issue
   logic                 issue_ff, issue_in;
   logic [SLOT_BITS-1:0] term_ff, term_in;

   // stage 1: relation to target frame and offset
   logic                 s1_valid_ff, s1_last_ff, s1_gt_ff, s1_lt_ff, s1_incnt_ff;
   logic                 s1_valid_in, s1_last_in, s1_gt_in, s1_lt_in, s1_incnt_in;
   logic [SLOT_BITS-1:0] s1_term_ff, s1_term_in;
   logic [OFF_BITS-1:0]  s1_off_ff, s1_off_in;
   logic [SLOT_BITS-1:0] diff;

   // stage 2: position in the rotated frame and use flag
   logic                 s2_valid_ff, s2_last_ff, s2_use_ff;
   logic                 s2_valid_in, s2_last_in, s2_use_in;
   logic [SLOT_BITS-1:0] s2_term_ff, s2_term_in;
   logic [POS_BITS-1:0]  s2_j_ff, s2_j_in;
   logic [OFF_BITS:0]    k_plus;

   // stage 3: aligned with frame store read data
   logic                 s3_valid_ff, s3_last_ff, s3_use_ff;
   logic [LEN_BITS-1:0]  idx_sum, idx;

   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] sum_ff, sum_in;
   logic                          sat_ff, sat_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [PROD_BITS-1:0]   rnd_sum;
   logic signed [RND_BITS-1:0]    rnd;
   logic signed [SAMPLE_BITS-1:0] res;
   logic                          res_sat;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [SIDX_BITS-1:0]              rsp_index_ff, rsp_index_in;
   logic signed [OUT_SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                              rsp_sat_ff, rsp_sat_in;
   logic                              out_free;
   logic                              finish;

   logic                   frame_wr_en, frame_rd_en;
   logic [FADDR_BITS-1:0]  frame_wr_addr, frame_rd_addr;
   logic [SAMPLE_BITS-1:0] frame_wr_data, frame_rd_data;
   logic                   win_wr_en, win_rd_en;
   logic [WIN_BITS-1:0]    win_rd_data;

   assign pop = head_valid && (state_ff == ST_IDLE);

   // store ports
   assign frame_wr_en   = pop && (head.kind == CMD_LOAD_FRAME);
   assign frame_wr_addr = {head.frame_index[SLOT_BITS-1:0], head.sample_index[POS_BITS-1:0]};
   assign frame_wr_data = SAMPLE_BITS'(head.value);
   assign win_wr_en     = pop && (head.kind == CMD_LOAD_WIN);
   assign win_rd_en     = pop && (head.kind == CMD_COMPUTE);

   stftola_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(MAX_FRAMES * MAX_FRAME_LEN)
   ) u_frame_ram (
      .clock  (clock),
      .wr_en  (frame_wr_en),
      .wr_addr(frame_wr_addr),
      .wr_data(frame_wr_data),
      .rd_en  (frame_rd_en),
      .rd_addr(frame_rd_addr),
      .rd_data(frame_rd_data)
   );

   stftola_ram #(
      .WIDTH(WIN_BITS),
      .DEPTH(MAX_FRAME_LEN)
   ) u_win_ram (
      .clock  (clock),
      .wr_en  (win_wr_en),
      .wr_addr(head.sample_index[POS_BITS-1:0]),
      .wr_data(head.value[WIN_BITS-1:0]),
      .rd_en  (win_rd_en),
      .rd_addr(head.sample_index[POS_BITS-1:0]),
      .rd_data(win_rd_data)
   );

   // stage 1
   always_comb begin
      s1_gt_in    = term_ff > cur_fi_ff[SLOT_BITS-1:0];
      s1_lt_in    = term_ff < cur_fi_ff[SLOT_BITS-1:0];
      diff        = s1_gt_in ? (term_ff - cur_fi_ff[SLOT_BITS-1:0])
                             : (cur_fi_ff[SLOT_BITS-1:0] - term_ff);
      s1_off_in   = OFF_BITS'(diff) * OFF_BITS'(cfg.hop);
      s1_incnt_in = (CNT_BITS'(term_ff) < cfg.cnt);
      s1_term_in  = term_ff;
      s1_valid_in = issue_ff;
      s1_last_in  = issue_ff && (term_ff == LAST_SLOT);
   end

   // stage 2
   assign k_plus = (OFF_BITS+1)'(cur_k_ff) + (OFF_BITS+1)'(s1_off_ff);

   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_last_in  = s1_last_ff;
      s2_term_in  = s1_term_ff;
      if (s1_gt_ff) begin
         s2_use_in = s1_incnt_ff && (s1_off_ff < cfg.len) && (cur_k_ff >= s1_off_ff);
         s2_j_in   = cur_k_ff - POS_BITS'(s1_off_ff);
      end else if (s1_lt_ff) begin
         s2_use_in = (s1_off_ff < cfg.len) && (k_plus < cfg.len);
         s2_j_in   = POS_BITS'(k_plus);
      end else begin
         s2_use_in = 1'b1;
         s2_j_in   = cur_k_ff;
      end
   end

   // stage 3: undo the half-length rotation and read the store
   assign idx_sum       = LEN_BITS'(s2_j_ff) + cfg.lo;
   assign idx           = (idx_sum >= cfg.len) ? (idx_sum - cfg.len) : idx_sum;
   assign frame_rd_addr = {s2_term_ff, idx[POS_BITS-1:0]};
   assign frame_rd_en   = s2_valid_ff && s2_use_ff;

   // final arithmetic
   assign rnd_sum = prod_ff + ROUND_HALF;
   assign rnd     = RND_BITS'(rnd_sum >>> ROUND_SHIFT);

   always_comb begin
      if (rnd > RND_MAX) begin
         res     = SUM_MAX;
         res_sat = 1'b1;
      end else if (rnd < RND_MIN) begin
         res     = SUM_MIN;
         res_sat = 1'b1;
      end else begin
         res     = SAMPLE_BITS'(rnd);
         res_sat = 1'b0;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign finish   = (state_ff == ST_ROUND) && out_free;

   always_comb begin
      state_in  = state_ff;
      issue_in  = issue_ff;
      term_in   = term_ff;
      cur_fi_in = cur_fi_ff;
      cur_si_in = cur_si_ff;
      cur_k_in  = cur_k_ff;
      acc_in    = acc_ff;
      sum_in    = sum_ff;
      sat_in    = sat_ff;
      prod_in   = prod_ff;

      if (issue_ff) begin
         term_in = term_ff + 1'b1;
         if (term_ff == LAST_SLOT) begin
            issue_in = 1'b0;
         end
      end

      if (s3_valid_ff && s3_use_ff) begin
         acc_in = acc_ff + ACC_BITS'($signed(frame_rd_data));
      end

      case (state_ff)
         ST_IDLE: begin
            if (pop && (head.kind == CMD_COMPUTE)) begin
               state_in  = ST_TERMS;
               issue_in  = 1'b1;
               term_in   = '0;
               cur_fi_in = head.frame_index;
               cur_si_in = head.sample_index;
               cur_k_in  = head.k;
               acc_in    = '0;
            end
         end
         ST_TERMS: begin
            if (s3_valid_ff && s3_last_ff) begin
               state_in = ST_CLIP;
            end
         end
         ST_CLIP: begin
            if (acc_ff > ACC_MAX) begin
               sum_in = SUM_MAX;
               sat_in = 1'b1;
            end else if (acc_ff < ACC_MIN) begin
               sum_in = SUM_MIN;
               sat_in = 1'b1;
            end else begin
               sum_in = SAMPLE_BITS'(acc_ff);
               sat_in = 1'b0;
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = sum_ff * $signed(win_rd_data);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: hold while stalled
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_sat_in    = rsp_sat_ff;
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_index_in  = cur_si_ff;
         rsp_sample_in = OUT_SAMPLE_BITS'(res);
         rsp_sat_in    = sat_ff || res_sat;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s1_last_ff   <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_last_ff   <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s3_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         s1_valid_ff  <= s1_valid_in;
         s1_last_ff   <= s1_last_in;
         s2_valid_ff  <= s2_valid_in;
         s2_last_ff   <= s2_last_in;
         s3_valid_ff  <= s2_valid_ff;
         s3_last_ff   <= s2_last_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff       <= term_in;
      cur_fi_ff     <= cur_fi_in;
      cur_si_ff     <= cur_si_in;
      cur_k_ff      <= cur_k_in;
      s1_term_ff    <= s1_term_in;
      s1_gt_ff      <= s1_gt_in;
      s1_lt_ff      <= s1_lt_in;
      s1_incnt_ff   <= s1_incnt_in;
      s1_off_ff     <= s1_off_in;
      s2_term_ff    <= s2_term_in;
      s2_use_ff     <= s2_use_in;
      s2_j_ff       <= s2_j_in;
      s3_use_ff     <= s2_use_ff;
      acc_ff        <= acc_in;
      sum_ff        <= sum_in;
      sat_ff        <= sat_in;
      prod_ff       <= prod_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign stat.pop  = pop;
   assign stat.busy = (state_ff != ST_IDLE);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_index  = rsp_index_ff;
   assign rsp_out_sample = rsp_sample_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the overlap-add windowed frame reconstruction block.
`timescale 1ns / 1ps

module tb_top;
   import stftola_pkg::*;

   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int STORE_DEPTH = MAX_FRAMES * MAX_FRAME_LEN;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES = 250;
   localparam int TARGET_ITEMS = 1320;

   typedef struct {
      logic [OP_BITS-1:0]    op;
      logic [FIDX_BITS-1:0]  frame_index;
      logic [SIDX_BITS-1:0]  sample_index;
      logic [VALUE_BITS-1:0] value;
   } ola_request_type;

   typedef struct packed {
      logic [SIDX_BITS-1:0]       out_index;
      logic [OUT_SAMPLE_BITS-1:0] out_sample;
      logic                       saturated;
   } ola_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [OP_BITS-1:0]                req_operation = '0;
   logic [FIDX_BITS-1:0]              req_frame_index = '0;
   logic [SIDX_BITS-1:0]              req_sample_index = '0;
   logic signed [VALUE_BITS-1:0]      req_value = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [SIDX_BITS-1:0]              rsp_out_index;
   logic signed [OUT_SAMPLE_BITS-1:0] rsp_out_sample;
   logic                              rsp_saturated;
   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]          paddr = '0;
   logic [CSR_DATA_BITS-1:0]          pwdata = '0;
   logic [CSR_DATA_BITS-1:0]          prdata;
   logic                              pready;

   stft_frame_overlap_add_window DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_frame_index  (req_frame_index),
      .req_sample_index (req_sample_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_index    (rsp_out_index),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_saturated    (rsp_saturated),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // predictor state: stores as seen by accepted loads, effective register settings
   logic signed [SAMPLE_BITS-1:0] frame_mem [STORE_DEPTH];
   logic signed [WIN_BITS-1:0]    win_mem [MAX_FRAME_LEN];
   int cur_len = MAX_FRAME_LEN;
   int cur_hop = int'(HOP_SIZE_RESET);
   int cur_cnt = MAX_FRAMES;

   // stimulus side bookkeeping of which entries have been loaded
   bit frame_set [STORE_DEPTH];
   bit win_set [MAX_FRAME_LEN];
   int tap_addr [MAX_FRAMES];

   ola_request_type stim_items [$];
   ola_sample_type  pending_samples [$];
   ola_request_type next_req;
   ola_sample_type  want_sample;

   int  items_made = 0;
   int  results_seen = 0;
   int  err_cnt = 0;
   int  cycle_cnt = 0;
   int  hold_left = 0;
   int  next_hold = 40;
   logic req_fire = 1'b0;
   logic calm;

   initial begin
      forever #5 clock = ~clock;
   end

   assign calm = (cycle_cnt >= 3000) && (cycle_cnt < 9000);

   // frame store addresses summed for target frame fi at position si
   function automatic int find_taps(int fi, int si);
      int k, off, j, n;
      n = 0;
      k = (si + cur_len - cur_len / 2) % cur_len;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         j = -1;
         if (i == fi) begin
            j = k;
         end else if (i > fi) begin
            off = (i - fi) * cur_hop;
            if (i < cur_cnt && off < cur_len && k >= off) j = k - off;
         end else begin
            off = (fi - i) * cur_hop;
            if (off < cur_len && k + off < cur_len) j = k + off;
         end
         if (j >= 0) begin
            tap_addr[n] = i * MAX_FRAME_LEN + (j + cur_len / 2) % cur_len;
            n++;
         end
      end
      return n;
   endfunction

   function automatic ola_sample_type overlap_add_sample(int fi, int si);
      longint acc, prod;
      int n;
      ola_sample_type r;
      n = find_taps(fi, si);
      acc = 0;
      r.saturated = 1'b0;
      for (int t = 0; t < n; t++) acc += longint'(frame_mem[tap_addr[t]]);
      if (acc > SAMPLE_MAX) begin
         acc = SAMPLE_MAX;
         r.saturated = 1'b1;
      end else if (acc < SAMPLE_MIN) begin
         acc = SAMPLE_MIN;
         r.saturated = 1'b1;
      end
      // round half up, floor shift keeps negative products right
      prod = (acc * longint'(win_mem[si]) + 64'sd32768) >>> 16;
      if (prod > SAMPLE_MAX) begin
         prod = SAMPLE_MAX;
         r.saturated = 1'b1;
      end else if (prod < SAMPLE_MIN) begin
         prod = SAMPLE_MIN;
         r.saturated = 1'b1;
      end
      r.out_index = si[SIDX_BITS-1:0];
      r.out_sample = prod[OUT_SAMPLE_BITS-1:0];
      return r;
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value();
      logic [VALUE_BITS-1:0] v;
      case ($urandom_range(0, 9))
         0: v = 24'h7FFFFF;
         1: v = 24'h800000;
         2: v = '0;
         default: v = VALUE_BITS'($urandom);
      endcase
      return v;
   endfunction

   function automatic void push_item(logic [OP_BITS-1:0] op, int fi, int si,
                                     logic [VALUE_BITS-1:0] v);
      ola_request_type it;
      it.op = op;
      it.frame_index = fi[FIDX_BITS-1:0];
      it.sample_index = si[SIDX_BITS-1:0];
      it.value = v;
      stim_items.push_back(it);
      if (op != OP_UNUSED) items_made++;
   endfunction

   function automatic void add_frame_load(int fi, int si, logic [VALUE_BITS-1:0] v);
      push_item(OP_LOAD_FRAME, fi, si, v);
      frame_set[fi * MAX_FRAME_LEN + si] = 1'b1;
   endfunction

   function automatic void add_window_load(int si, logic [VALUE_BITS-1:0] v);
      push_item(OP_LOAD_WIN, 0, si, v);
      win_set[si] = 1'b1;
   endfunction

   // load whatever the compute will read and has never been written, then the compute
   function automatic void add_compute(int fi, int si, bit fixed_fill,
                                       logic [VALUE_BITS-1:0] frame_fill,
                                       logic [VALUE_BITS-1:0] win_fill);
      int n;
      if (si < cur_len) begin
         n = find_taps(fi, si);
         for (int t = 0; t < n; t++) begin
            if (!frame_set[tap_addr[t]])
               add_frame_load(tap_addr[t] / MAX_FRAME_LEN, tap_addr[t] % MAX_FRAME_LEN,
                              fixed_fill ? frame_fill : pick_value());
         end
         if (!win_set[si]) add_window_load(si, fixed_fill ? win_fill : VALUE_BITS'($urandom));
      end
      push_item(OP_COMPUTE, fi, si, VALUE_BITS'($urandom));
   endfunction

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input int field);
      logic [CSR_DATA_BITS-1:0] data;
      int raw;
      data = $urandom;
      case (idx)
         REG_FRAME_LENGTH: data[CFG_LEN_BITS-1:0] = field[CFG_LEN_BITS-1:0];
         REG_HOP_SIZE:     data[CFG_HOP_BITS-1:0] = field[CFG_HOP_BITS-1:0];
         default:          data[CFG_CNT_BITS-1:0] = field[CFG_CNT_BITS-1:0];
      endcase
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_FRAME_LENGTH: begin
            raw = int'(data[CFG_LEN_BITS-1:0]);
            cur_len = (raw == 0) ? 1 : ((raw > MAX_FRAME_LEN) ? MAX_FRAME_LEN : raw);
         end
         REG_HOP_SIZE: cur_hop = int'(data[CFG_HOP_BITS-1:0]);
         default: begin
            raw = int'(data[CFG_CNT_BITS-1:0]);
            cur_cnt = (raw > MAX_FRAMES) ? MAX_FRAMES : raw;
         end
      endcase
   endtask

   // hold until the driver is empty and every result is in, then let loads settle
   task automatic wait_idle();
      @(negedge clock);
      while (stim_items.size() != 0 || req_valid || pending_samples.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(int len_raw, int hop_raw, int cnt_raw, int slots);
      int fi, si, pick;
      write_reg(REG_FRAME_LENGTH, len_raw);
      write_reg(REG_HOP_SIZE, hop_raw);
      write_reg(REG_FRAME_COUNT, cnt_raw);
      for (int s = 0; s < slots; s++) begin
         fi = $urandom_range(0, MAX_FRAMES - 1);
         if ($urandom_range(0, 3) == 0) si = $urandom_range(0, MAX_FRAME_LEN - 1);
         else si = $urandom_range(0, cur_len - 1);
         pick = $urandom_range(0, 19);
         if (pick < 11) add_compute(fi, si, 1'b0, '0, '0);
         else if (pick < 15) add_frame_load(fi, si, pick_value());
         else if (pick < 18) add_window_load(si, VALUE_BITS'($urandom));
         else if (pick < 19) push_item(OP_UNUSED, fi, si, VALUE_BITS'($urandom));
         else add_compute(fi, cur_len - 1, 1'b0, '0, '0);
      end
      wait_idle();
   endtask

   initial begin
      int len_raw, hop_raw, slots;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed part under the reset settings
      add_compute(MAX_FRAMES - 1, MAX_FRAME_LEN - 1, 1'b1, 24'h7FFFFF, {6'b101010, 18'h1FFFF});
      add_compute(0, 0, 1'b1, 24'h800000, 24'h01FFFF);
      push_item(OP_UNUSED, MAX_FRAMES - 1, MAX_FRAME_LEN - 1, 24'hFFFFFF);
      add_compute(8, 511, 1'b1, 24'h000001, 24'h000000);
      add_compute(5, 300, 1'b1, 24'hFFFFFF, 24'hFE0000);
      wait_idle();

      // fixed corners of the register space
      run_phase(0, 5, 16, 30);
      run_phase(1, 0, 0, 30);
      run_phase(2, 1, 31, 40);
      run_phase(2047, 1, 16, 16);
      run_phase(1024, 2047, 16, 20);
      run_phase(7, 0, 16, 40);
      run_phase(16, 1024, 5, 40);
      run_phase(33, 3, 1, 40);

      while (items_made < TARGET_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            len_raw = $urandom_range(513, 2047);
            slots = 16;
         end else if ($urandom_range(0, 3) == 0) begin
            len_raw = $urandom_range(65, 256);
            slots = 40;
         end else begin
            len_raw = $urandom_range(0, 64);
            slots = 60;
         end
         case ($urandom_range(0, 5))
            0: hop_raw = 0;
            1: hop_raw = 1;
            2: hop_raw = 2047;
            default: hop_raw = $urandom_range(0, len_raw);
         endcase
         run_phase(len_raw, hop_raw, $urandom_range(0, 31), slots);
      end

      wait_idle();
      if (err_cnt == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (stim_items.size() != 0 && (calm || $urandom_range(0, 99) >= 36)) begin
            next_req = stim_items.pop_front();
            req_valid <= 1'b1;
            req_operation <= next_req.op;
            req_frame_index <= next_req.frame_index;
            req_sample_index <= next_req.sample_index;
            req_value <= next_req.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls plus a long hold-off while requests keep coming
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (results_seen >= next_hold && stim_items.size() > 30) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         next_hold <= next_hold + 400;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 36);
      end
   end

   // request monitor: update the stores and predict each result on transfer
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            case (req_operation)
               OP_LOAD_FRAME:
                  frame_mem[int'(req_frame_index) * MAX_FRAME_LEN + int'(req_sample_index)] =
                     req_value;
               OP_LOAD_WIN: win_mem[req_sample_index] = req_value[WIN_BITS-1:0];
               OP_COMPUTE: begin
                  if (int'(req_sample_index) < cur_len)
                     pending_samples.push_back(
                        overlap_add_sample(int'(req_frame_index), int'(req_sample_index)));
               end
               default: ;
            endcase
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (pending_samples.size() == 0) begin
            $error("unexpected result: out_index %0d out_sample %0d", rsp_out_index,
                   rsp_out_sample);
            err_cnt++;
         end else begin
            want_sample = pending_samples.pop_front();
            if (rsp_out_index !== want_sample.out_index) begin
               $error("out_index: expected %0d, got %0d", want_sample.out_index,
                      rsp_out_index);
               err_cnt++;
            end
            if (rsp_out_sample !== want_sample.out_sample) begin
               $error("out_sample: expected %0d, got %0d", $signed(want_sample.out_sample),
                      rsp_out_sample);
               err_cnt++;
            end
            if (rsp_saturated !== want_sample.saturated) begin
               $error("saturated: expected %0d, got %0d", want_sample.saturated,
                      rsp_saturated);
               err_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

endmodule
